// ===== rtl/qsi_pkg.sv =====
// Shared types, constants and fixed-point helpers of the quintic segment interpolator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package qsi_pkg;

  // Normalized abscissa t is Q.30; weights fit in 31 bits (they never exceed 1.0)
  localparam int T_BITS    = 30;
  localparam int W_W       = T_BITS + 1;
  localparam int DIV_STEPS = T_BITS + 1;
  localparam int XW        = 32;
  localparam int MAG_W     = 60;
  localparam int PROD_W    = 128;

  localparam logic [33:0] T_ONE = 34'd1 << T_BITS;
  localparam logic [MAG_W-1:0] TERM_CAP = MAG_W'(1) << 59;

  // Register indexes of the configuration port
  localparam logic [2:0] CFG_START_POS   = 3'd0;
  localparam logic [2:0] CFG_END_POS     = 3'd1;
  localparam logic [2:0] CFG_START_VALUE = 3'd2;
  localparam logic [2:0] CFG_END_VALUE   = 3'd3;
  localparam logic [2:0] CFG_START_SLOPE = 3'd4;
  localparam logic [2:0] CFG_END_SLOPE   = 3'd5;
  localparam logic [2:0] CFG_START_ACCEL = 3'd6;
  localparam logic [2:0] CFG_END_ACCEL   = 3'd7;

  // Result region codes
  typedef enum logic [2:0] {
    REG_INSIDE = 3'd0,
    REG_BEFORE = 3'd1,
    REG_AFTER  = 3'd2,
    REG_ZERO   = 3'd3,
    REG_SAT    = 3'd4
  } region_t;

  // Per-stage control that travels with the data
  typedef struct packed {
    logic    vld;
    region_t region;
  } qsi_ctl_t;

  // Q.30 product, rounded half up
  function automatic logic [W_W-1:0] qmul(input logic [33:0] a, input logic [33:0] b);
    logic [67:0] p;
    p = (68'(a) * 68'(b)) + (68'd1 << (T_BITS - 1));
    return p[T_BITS +: W_W];
  endfunction

  // p / 2^s rounded half up, clamped to 2^59
  function automatic logic [MAG_W-1:0] round_cap(input logic [PROD_W-1:0] p,
                                                 input int unsigned s);
    logic [PROD_W-1:0] r;
    r = (p + (PROD_W'(1) << (s - 1))) >> s;
    if (r > PROD_W'(TERM_CAP)) begin
      return TERM_CAP;
    end
    return r[MAG_W-1:0];
  endfunction

  // Magnitude of a 32-bit two's complement value
  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/quintic_segment_interpolator_core.sv =====
// Top level of the quintic segment interpolator: configuration registers, input skid,
// front classification, and the divider, basis and term pipelines. Depends on qsi_pkg.
//
// Evaluates a quintic Hermite segment between start_pos and end_pos at each x_in beat
// (signed Q16.16) and returns y_out with a region code in tuser. The pipeline takes
// one beat per clock unless a result waits on m_tready. Each beat passes the front stage,
// which loads on the accepting edge, then the 32-stage bit-per-stage divider (a load
// stage and 31 quotient steps) that normalizes x into t, then five basis stages and six
// term stages. A one-beat input skid keeps s_tready high for one more beat while a
// result waits on m_tready. The h*h factor is derived from the configuration registers
// through the hprod and then the hsq register after a write.
`timescale 1ns / 1ps
`default_nettype none

module quintic_segment_interpolator_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input stream, tdata: x_in[31:0]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,
  // output stream, tdata: y_out[31:0]; tuser: region[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,
  output logic [2:0]  m_tuser,
  // configuration writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import qsi_pkg::*;

  localparam int HSQ_W = 64 - FRAC_BITS;

  logic [31:0] start_pos, end_pos, start_value, end_value;
  logic [31:0] start_slope, end_slope, start_accel, end_accel;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_pos   <= 32'd0;
      end_pos     <= 32'd65536;
      start_value <= 32'd0;
      end_value   <= 32'd0;
      start_slope <= 32'd0;
      end_slope   <= 32'd0;
      start_accel <= 32'd0;
      end_accel   <= 32'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_POS:   start_pos   <= cfg_data;
        CFG_END_POS:     end_pos     <= cfg_data;
        CFG_START_VALUE: start_value <= cfg_data;
        CFG_END_VALUE:   end_value   <= cfg_data;
        CFG_START_SLOPE: start_slope <= cfg_data;
        CFG_END_SLOPE:   end_slope   <= cfg_data;
        CFG_START_ACCEL: start_accel <= cfg_data;
        CFG_END_ACCEL:   end_accel   <= cfg_data;
        default: ;
      endcase
    end
  end

  // h^2 / 2^FRAC_BITS from the configuration
  logic [31:0]      h_cfg;
  logic [63:0]      hprod;
  logic [64:0]      hsq_wide;
  logic [HSQ_W-1:0] hsq;

  always_comb begin
    h_cfg    = 32'(end_pos - start_pos);
    hsq_wide = (65'(hprod) + (65'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    hprod <= 64'(h_cfg) * 64'(h_cfg);
    hsq   <= hsq_wide[HSQ_W-1:0];
  end

  // Pipeline advance and input skid
  logic        en, in_take, skid_vld, v_sel;
  logic [31:0] skid_data, x_sel;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = !skid_vld;
  assign in_take  = s_tvalid && s_tready;
  assign v_sel    = skid_vld || in_take;
  assign x_sel    = skid_vld ? skid_data : s_tdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_vld <= 1'b0;
    end else if (en) begin
      skid_vld <= 1'b0;
    end else if (in_take) begin
      skid_vld <= 1'b1;
    end
    if (!en && in_take) begin
      skid_data <= s_tdata;
    end
  end

  // Front stage: classify x and form u and h
  qsi_ctl_t    f0_ctl;
  logic [31:0] f0_u, f0_h;
  region_t     cls;

  always_comb begin
    priority if ($signed(x_sel) < $signed(start_pos)) begin
      cls = REG_BEFORE;
    end else if ($signed(x_sel) > $signed(end_pos)) begin
      cls = REG_AFTER;
    end else if (end_pos == start_pos) begin
      cls = REG_ZERO;
    end else begin
      cls = REG_INSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f0_ctl.vld <= 1'b0;
    end else if (en) begin
      f0_ctl.vld    <= v_sel;
      f0_ctl.region <= cls;
    end
    if (en) begin
      f0_u <= 32'(x_sel - start_pos);
      f0_h <= h_cfg;
    end
  end

  // Divider, basis weights, terms
  qsi_ctl_t       div_ctl, bas_ctl;
  logic [W_W-1:0] div_t;
  logic [31:0]    div_h, bas_h;
  logic [W_W-1:0] w_h1, w_g2, w_g3, w_g4, w_g5;
  region_t        out_region;

  qsi_div u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (f0_ctl),
    .u_in    (f0_u),
    .h_in    (f0_h),
    .ctl_out (div_ctl),
    .t_out   (div_t),
    .h_out   (div_h)
  );

  qsi_basis u_basis (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (div_ctl),
    .t_in    (div_t),
    .h_in    (div_h),
    .ctl_out (bas_ctl),
    .h_out   (bas_h),
    .h1      (w_h1),
    .g2      (w_g2),
    .g3      (w_g3),
    .g4      (w_g4),
    .g5      (w_g5)
  );

  qsi_terms #(
    .FRAC_BITS (FRAC_BITS)
  ) u_terms (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .ctl_in      (bas_ctl),
    .h_in        (bas_h),
    .h1          (w_h1),
    .g2          (w_g2),
    .g3          (w_g3),
    .g4          (w_g4),
    .g5          (w_g5),
    .hsq         (hsq),
    .start_value (start_value),
    .end_value   (end_value),
    .start_slope (start_slope),
    .end_slope   (end_slope),
    .start_accel (start_accel),
    .end_accel   (end_accel),
    .out_vld     (m_tvalid),
    .y_out       (m_tdata),
    .region      (out_region)
  );

  assign m_tuser = out_region;

  // A saturated result sits at one of the two 32-bit limits
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == REG_SAT) |-> (m_tdata == 32'h7fff_ffff) ||
                                         (m_tdata == 32'h8000_0000))
    else $error("saturated beat not at a limit");

  // A parked beat in the skid stays until the pipeline moves
  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    skid_vld && !en |=> skid_vld)
    else $error("skid beat dropped while stalled");

  // A beat taken straight into a moving pipeline shows up in the front stage
  a_front_load: assert property (@(posedge clk) disable iff (rst)
    en && in_take && !skid_vld |=> f0_ctl.vld)
    else $error("accepted beat missing from front stage");

endmodule

`default_nettype wire

// ===== rtl/qsi_div.sv =====
// Pipelined restoring divider: t = round(u * 2^30 / h), one quotient bit per stage.
// Depends on qsi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qsi_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  qsi_pkg::qsi_ctl_t             ctl_in,
  input  logic [31:0]                   u_in,
  input  logic [31:0]                   h_in,
  output qsi_pkg::qsi_ctl_t             ctl_out,
  output logic [qsi_pkg::W_W-1:0]       t_out,
  output logic [31:0]                   h_out
);
  import qsi_pkg::*;

  qsi_ctl_t               ctl  [DIV_STEPS+1];
  logic [31:0]            rem  [DIV_STEPS+1];
  logic [DIV_STEPS-1:0]   rest [DIV_STEPS+1];
  logic [DIV_STEPS-1:0]   quo  [DIV_STEPS+1];
  logic [31:0]            hreg [DIV_STEPS+1];
  logic [62:0]            num;

  // Numerator with the half-divisor rounding term
  assign num = (63'(u_in) << T_BITS) + 63'(h_in[31:1]);

  // Load stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0].vld <= 1'b0;
    end else if (en) begin
      ctl[0] <= ctl_in;
    end
    if (en) begin
      rem[0]  <= num[62:DIV_STEPS];
      rest[0] <= num[DIV_STEPS-1:0];
      quo[0]  <= '0;
      hreg[0] <= h_in;
    end
  end

  // One restoring step per stage; the partial remainder stays below h
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic [32:0] r2;
    logic        ge;

    always_comb begin
      r2 = {rem[i], rest[i][DIV_STEPS-1]};
      ge = (r2 >= {1'b0, hreg[i]});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[i+1].vld <= 1'b0;
      end else if (en) begin
        ctl[i+1] <= ctl[i];
      end
      if (en) begin
        rem[i+1]  <= ge ? 32'(r2 - {1'b0, hreg[i]}) : r2[31:0];
        rest[i+1] <= rest[i] << 1;
        quo[i+1]  <= {quo[i][DIV_STEPS-2:0], ge};
        hreg[i+1] <= hreg[i];
      end
    end
  end

  assign ctl_out = ctl[DIV_STEPS];
  assign t_out   = quo[DIV_STEPS];
  assign h_out   = hreg[DIV_STEPS];

endmodule

`default_nettype wire

// ===== rtl/qsi_basis.sv =====
// Hermite basis weights from the normalized abscissa t, five pipeline stages.
// Depends on qsi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qsi_basis (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  qsi_pkg::qsi_ctl_t        ctl_in,
  input  logic [qsi_pkg::W_W-1:0]  t_in,
  input  logic [31:0]              h_in,
  output qsi_pkg::qsi_ctl_t        ctl_out,
  output logic [31:0]              h_out,
  output logic [qsi_pkg::W_W-1:0]  h1,
  output logic [qsi_pkg::W_W-1:0]  g2,
  output logic [qsi_pkg::W_W-1:0]  g3,
  output logic [qsi_pkg::W_W-1:0]  g4,
  output logic [qsi_pkg::W_W-1:0]  g5
);
  import qsi_pkg::*;

  qsi_ctl_t       ctl0, ctl1, ctl2, ctl3, ctl4;
  logic [31:0]    h0, h1r, h2, h3, h4;
  logic [W_W-1:0] t0, s0;
  logic [W_W-1:0] t1, s1, t2_1, s2_1;
  logic [W_W-1:0] t2r, s2r, t2_2, s2_2, t3_2, s3_2;
  logic [33:0]    inner2;
  logic [W_W-1:0] h1_3, ts3_3, t3s_3, g4_3, g5_3;
  logic [32:0]    p2_3, p3_3;
  logic [36:0]    inner_pos, inner_neg;

  // 10 - 15t + 6t^2, never below zero
  always_comb begin
    inner_pos = (37'd10 << T_BITS) + 37'd6 * 37'(t2_1);
    inner_neg = 37'd15 * 37'(t1);
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl0.vld <= 1'b0;
      ctl1.vld <= 1'b0;
      ctl2.vld <= 1'b0;
      ctl3.vld <= 1'b0;
      ctl4.vld <= 1'b0;
    end else if (en) begin
      ctl0 <= ctl_in;
      ctl1 <= ctl0;
      ctl2 <= ctl1;
      ctl3 <= ctl2;
      ctl4 <= ctl3;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (en) begin
      // s = 1 - t
      t0 <= t_in;
      s0 <= W_W'(T_ONE - 34'(t_in));
      h0 <= h_in;
      // squares
      t1   <= t0;
      s1   <= s0;
      t2_1 <= qmul(34'(t0), 34'(t0));
      s2_1 <= qmul(34'(s0), 34'(s0));
      h1r  <= h0;
      // cubes and the inner polynomial of H1
      t2r    <= t1;
      s2r    <= s1;
      t2_2   <= t2_1;
      s2_2   <= s2_1;
      t3_2   <= qmul(34'(t2_1), 34'(t1));
      s3_2   <= qmul(34'(s2_1), 34'(s1));
      inner2 <= (inner_pos < inner_neg) ? 34'd0 : 34'(inner_pos - inner_neg);
      h2     <= h1r;
      // weight products
      h1_3  <= qmul(34'(t3_2), inner2);
      ts3_3 <= qmul(34'(t2r), 34'(s3_2));
      t3s_3 <= qmul(34'(t3_2), 34'(s2r));
      g4_3  <= qmul(34'(t2_2), 34'(s3_2));
      g5_3  <= qmul(34'(t3_2), 34'(s2_2));
      p2_3  <= 33'(T_ONE + 34'd3 * 34'(t2r));
      p3_3  <= 33'((T_ONE << 2) - 34'd3 * 34'(t2r));
      h3    <= h2;
      // slope weights
      h1 <= h1_3;
      g2 <= qmul(34'(ts3_3), 34'(p2_3));
      g3 <= qmul(34'(t3s_3), 34'(p3_3));
      g4 <= g4_3;
      g5 <= g5_3;
      h4 <= h3;
    end
  end

  assign ctl_out = ctl4;
  assign h_out   = h4;

endmodule

`default_nettype wire

// ===== rtl/qsi_terms.sv =====
// Weighted terms, their sum and the final saturation and region select.
// Depends on qsi_pkg; the last stage is the output register of the block.
`timescale 1ns / 1ps
`default_nettype none

module qsi_terms #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  qsi_pkg::qsi_ctl_t        ctl_in,
  input  logic [31:0]              h_in,
  input  logic [qsi_pkg::W_W-1:0]  h1,
  input  logic [qsi_pkg::W_W-1:0]  g2,
  input  logic [qsi_pkg::W_W-1:0]  g3,
  input  logic [qsi_pkg::W_W-1:0]  g4,
  input  logic [qsi_pkg::W_W-1:0]  g5,
  input  logic [63-FRAC_BITS:0]    hsq,
  input  logic [31:0]              start_value,
  input  logic [31:0]              end_value,
  input  logic [31:0]              start_slope,
  input  logic [31:0]              end_slope,
  input  logic [31:0]              start_accel,
  input  logic [31:0]              end_accel,
  output logic                     out_vld,
  output logic [31:0]              y_out,
  output qsi_pkg::region_t         region
);
  import qsi_pkg::*;

  localparam int HSQ_W   = 64 - FRAC_BITS;
  localparam int HL      = HSQ_W / 2;
  localparam int HH      = HSQ_W - HL;
  localparam int S_DV    = T_BITS;
  localparam int S_SLOPE = T_BITS + FRAC_BITS;
  localparam int S_ACCEL = T_BITS + 1 + FRAC_BITS;

  // Config-derived magnitudes and term signs
  logic signed [32:0] dv;
  logic [32:0]        mdv;
  logic [31:0]        mss, mes, msa, mea;
  logic               neg_dv, neg_ss, neg_es, neg_sa, neg_ea;

  always_comb begin
    dv     = $signed({end_value[31], end_value}) - $signed({start_value[31], start_value});
    mdv    = dv[32] ? (~dv + 33'd1) : dv;
    mss    = mag32(start_slope);
    mes    = mag32(end_slope);
    msa    = mag32(start_accel);
    mea    = mag32(end_accel);
    neg_dv = dv[32];
    neg_ss = start_slope[31];
    neg_es = !end_slope[31];
    neg_sa = start_accel[31];
    neg_ea = end_accel[31];
  end

  qsi_ctl_t ctl_a, ctl_b, ctl_c, ctl_d, ctl_e;

  logic [63:0]        pa_a;
  logic [62:0]        g2h_a, g3h_a, am4_a, am5_a;
  logic [63:0]        pa_b;
  logic [63:0]        s2lo_b, s3lo_b;
  logic [62:0]        s2hi_b, s3hi_b;
  logic [31+HL:0]     a4ll_b, a5ll_b;
  logic [31+HH:0]     a4lh_b, a5lh_b;
  logic [30+HL:0]     a4hl_b, a5hl_b;
  logic [30+HH:0]     a4hh_b, a5hh_b;
  logic [PROD_W-1:0]  p1_c, p2_c, p3_c, p4_c, p5_c;
  logic signed [MAG_W:0] tm1_d, tm2_d, tm3_d, tm4_d, tm5_d;
  logic signed [63:0] sum_e;
  logic [MAG_W-1:0]   r1, r2, r3, r4, r5;

  always_comb begin
    r1 = round_cap(p1_c, S_DV);
    r2 = round_cap(p2_c, S_SLOPE);
    r3 = round_cap(p3_c, S_SLOPE);
    r4 = round_cap(p4_c, S_ACCEL);
    r5 = round_cap(p5_c, S_ACCEL);
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a.vld <= 1'b0;
      ctl_b.vld <= 1'b0;
      ctl_c.vld <= 1'b0;
      ctl_d.vld <= 1'b0;
      ctl_e.vld <= 1'b0;
      out_vld   <= 1'b0;
    end else if (en) begin
      ctl_a   <= ctl_in;
      ctl_b   <= ctl_a;
      ctl_c   <= ctl_b;
      ctl_d   <= ctl_c;
      ctl_e   <= ctl_d;
      out_vld <= ctl_e.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // first products: weight times h or times a magnitude
      pa_a  <= 64'(mdv) * 64'(h1);
      g2h_a <= 63'(g2) * 63'(h_in);
      g3h_a <= 63'(g3) * 63'(h_in);
      am4_a <= 63'(msa) * 63'(g4);
      am5_a <= 63'(mea) * 63'(g5);
      // partial products of the wide second multiplications
      pa_b   <= pa_a;
      s2lo_b <= 64'(mss) * 64'(g2h_a[31:0]);
      s2hi_b <= 63'(mss) * 63'(g2h_a[62:32]);
      s3lo_b <= 64'(mes) * 64'(g3h_a[31:0]);
      s3hi_b <= 63'(mes) * 63'(g3h_a[62:32]);
      a4ll_b <= (32+HL)'(am4_a[31:0])  * (32+HL)'(hsq[HL-1:0]);
      a4lh_b <= (32+HH)'(am4_a[31:0])  * (32+HH)'(hsq[HSQ_W-1:HL]);
      a4hl_b <= (31+HL)'(am4_a[62:32]) * (31+HL)'(hsq[HL-1:0]);
      a4hh_b <= (31+HH)'(am4_a[62:32]) * (31+HH)'(hsq[HSQ_W-1:HL]);
      a5ll_b <= (32+HL)'(am5_a[31:0])  * (32+HL)'(hsq[HL-1:0]);
      a5lh_b <= (32+HH)'(am5_a[31:0])  * (32+HH)'(hsq[HSQ_W-1:HL]);
      a5hl_b <= (31+HL)'(am5_a[62:32]) * (31+HL)'(hsq[HL-1:0]);
      a5hh_b <= (31+HH)'(am5_a[62:32]) * (31+HH)'(hsq[HSQ_W-1:HL]);
      // full products
      p1_c <= PROD_W'(pa_b);
      p2_c <= PROD_W'(s2lo_b) + (PROD_W'(s2hi_b) << 32);
      p3_c <= PROD_W'(s3lo_b) + (PROD_W'(s3hi_b) << 32);
      p4_c <= PROD_W'(a4ll_b) + (PROD_W'(a4lh_b) << HL)
            + (PROD_W'(a4hl_b) << 32) + (PROD_W'(a4hh_b) << (32 + HL));
      p5_c <= PROD_W'(a5ll_b) + (PROD_W'(a5lh_b) << HL)
            + (PROD_W'(a5hl_b) << 32) + (PROD_W'(a5hh_b) << (32 + HL));
      // rounded, clamped, signed terms
      tm1_d <= neg_dv ? -$signed({1'b0, r1}) : $signed({1'b0, r1});
      tm2_d <= neg_ss ? -$signed({1'b0, r2}) : $signed({1'b0, r2});
      tm3_d <= neg_es ? -$signed({1'b0, r3}) : $signed({1'b0, r3});
      tm4_d <= neg_sa ? -$signed({1'b0, r4}) : $signed({1'b0, r4});
      tm5_d <= neg_ea ? -$signed({1'b0, r5}) : $signed({1'b0, r5});
      // sum onto the start value
      sum_e <= 64'($signed(start_value)) + 64'(tm1_d) + 64'(tm2_d) + 64'(tm3_d)
             + 64'(tm4_d) + 64'(tm5_d);
      // saturate and pick the special cases
      unique case (ctl_e.region)
        REG_BEFORE: begin
          y_out  <= start_value;
          region <= REG_BEFORE;
        end
        REG_AFTER: begin
          y_out  <= end_value;
          region <= REG_AFTER;
        end
        REG_ZERO: begin
          y_out  <= start_value;
          region <= REG_ZERO;
        end
        default: begin
          if (sum_e > 64'sd2147483647) begin
            y_out  <= 32'h7fff_ffff;
            region <= REG_SAT;
          end else if (sum_e < -64'sd2147483648) begin
            y_out  <= 32'h8000_0000;
            region <= REG_SAT;
          end else begin
            y_out  <= sum_e[31:0];
            region <= REG_INSIDE;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/quintic_segment_interpolator_core_tb.sv =====
// Self-checking testbench for quintic_segment_interpolator_core: directed and random x beats
// over several segment settings, checked against an in-bench fixed-point predictor.
// Depends on qsi_pkg and the core RTL.
`timescale 1ns / 1ps

module quintic_segment_interpolator_core_tb;
  import qsi_pkg::*;

  localparam int LATENCY = 44;
  localparam logic [63:0] CAP = 64'd1 << 59;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  // Segment settings as the bench believes them, indexed by register index
  logic [31:0] seg_reg [8];

  typedef struct packed {
    logic [31:0] y;
    region_t     region;
  } y_beat_t;

  logic [31:0] x_pending [$];
  y_beat_t     y_expected [$];
  int          fail_count;
  bit          steady;

  quintic_segment_interpolator_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Q.30 product, 64-bit wrap like the spec arithmetic
  function automatic logic [63:0] q30(input logic [63:0] a, input logic [63:0] b);
    return (a * b + 64'd536870912) >> 30;
  endfunction

  // a*b / 2^s rounded half up over the full product, clamped to 2^59
  function automatic logic [63:0] scaled(input logic [63:0] a, input logic [63:0] b,
                                         input int s);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b} + (128'd1 << (s - 1))) >> s;
    return (p > {64'd0, CAP}) ? CAP : p[63:0];
  endfunction

  function automatic longint sx(input logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic logic [63:0] abs64(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic y_beat_t interpolate(input logic [31:0] xin);
    y_beat_t     r;
    longint      x, sp, ep, y, inner, dv, sl0, sl1, ac0, ac1, tm;
    logic [63:0] h, u, t, sv, t2, t3, s2, s3, h1, g2, g3, g4, g5, hsq;
    x = sx(xin);
    sp = sx(seg_reg[CFG_START_POS]);
    ep = sx(seg_reg[CFG_END_POS]);
    if (x < sp) begin
      r.y = seg_reg[CFG_START_VALUE];
      r.region = REG_BEFORE;
    end else if (x > ep) begin
      r.y = seg_reg[CFG_END_VALUE];
      r.region = REG_AFTER;
    end else if (ep == sp) begin
      r.y = seg_reg[CFG_START_VALUE];
      r.region = REG_ZERO;
    end else begin
      h = 64'(ep - sp);
      u = 64'(x - sp);
      t = ((u << 30) + (h >> 1)) / h;
      sv = (64'd1 << 30) - t;
      t2 = q30(t, t);
      t3 = q30(t2, t);
      s2 = q30(sv, sv);
      s3 = q30(s2, sv);
      inner = 10 * (longint'(1) << 30) - 15 * longint'(t) + 6 * longint'(t2);
      if (inner < 0) inner = 0;
      h1 = q30(t3, 64'(inner));
      g2 = q30(q30(t, s3), (64'd1 << 30) + 3 * t);
      g3 = q30(q30(t3, sv), 4 * (64'd1 << 30) - 3 * t);
      g4 = q30(t2, s3);
      g5 = q30(t3, s2);
      hsq = scaled(h, h, 16);
      dv = sx(seg_reg[CFG_END_VALUE]) - sx(seg_reg[CFG_START_VALUE]);
      sl0 = sx(seg_reg[CFG_START_SLOPE]);
      sl1 = sx(seg_reg[CFG_END_SLOPE]);
      ac0 = sx(seg_reg[CFG_START_ACCEL]);
      ac1 = sx(seg_reg[CFG_END_ACCEL]);
      y = sx(seg_reg[CFG_START_VALUE]);
      tm = longint'(scaled(abs64(dv), h1, 30));
      y += (dv < 0) ? -tm : tm;
      tm = longint'(scaled(abs64(sl0), g2 * h, 46));
      y += (sl0 < 0) ? -tm : tm;
      // end slope enters negated
      tm = longint'(scaled(abs64(sl1), g3 * h, 46));
      y += (sl1 < 0) ? tm : -tm;
      tm = longint'(scaled(abs64(ac0) * g4, hsq, 47));
      y += (ac0 < 0) ? -tm : tm;
      tm = longint'(scaled(abs64(ac1) * g5, hsq, 47));
      y += (ac1 < 0) ? -tm : tm;
      r.region = REG_INSIDE;
      if (y > 64'sd2147483647) begin
        y = 64'sd2147483647;
        r.region = REG_SAT;
      end else if (y < -64'sd2147483648) begin
        y = -64'sd2147483648;
        r.region = REG_SAT;
      end
      r.y = y[31:0];
    end
    return r;
  endfunction

  // Driver: feeds x beats from the pending queue with random gap bursts
  int send_gap;
  always @(posedge clk) begin
    logic        nv;
    logic [31:0] nd;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      send_gap = 0;
    end else begin
      nv = s_tvalid;
      nd = s_tdata;
      if (s_tvalid && s_tready) begin
        y_expected.push_back(interpolate(s_tdata));
        nv = 1'b0;
      end
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (x_pending.size() > 0) begin
          if (!steady && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(1, 16);
          end else begin
            nv = 1'b1;
            nd = x_pending.pop_front();
          end
        end
      end
      s_tvalid <= nv;
      s_tdata <= nd;
    end
  end

  // Monitor: random back-pressure bursts, compares each y beat with the oldest prediction
  int stall;
  always @(posedge clk) begin
    y_beat_t e;
    if (rst) begin
      m_tready <= 1'b0;
      stall = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (y_expected.size() == 0) begin
          $error("unexpected y beat: y_out %h region %0d", m_tdata, m_tuser);
          fail_count++;
        end else begin
          e = y_expected.pop_front();
          if (m_tdata !== e.y) begin
            $error("y_out mismatch: expected %h actual %h", e.y, m_tdata);
            fail_count++;
          end
          if (m_tuser !== e.region) begin
            $error("region mismatch: expected %0d actual %0d", e.region, m_tuser);
            fail_count++;
          end
        end
      end
      if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else if (!steady && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 16);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Write all eight segment registers back to back
  task automatic load_segment(input logic [31:0] vals [8]);
    for (int i = 0; i < 8; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      seg_reg[i] = vals[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Block until every queued beat has come back, then let the pipe drain
  task automatic drain();
    while (x_pending.size() > 0 || s_tvalid || y_expected.size() > 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  // Random x mostly inside the segment, some outside and some anywhere
  task automatic queue_random(input int n);
    longint sp, ep, v;
    logic [63:0] span;
    for (int k = 0; k < n; k++) begin
      sp = sx(seg_reg[CFG_START_POS]);
      ep = sx(seg_reg[CFG_END_POS]);
      case ($urandom_range(0, 9))
        0: v = sp - 1 - longint'($urandom_range(0, 1000));
        1: v = ep + 1 + longint'($urandom_range(0, 1000));
        2: v = sx($urandom);
        3: v = ($urandom_range(0, 1)) ? sp : ep;
        default: begin
          if (ep >= sp) begin
            span = 64'(ep - sp) + 64'd1;
            v = sp + longint'({$urandom, $urandom} % span);
          end else begin
            v = sx($urandom);
          end
        end
      endcase
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      x_pending.push_back(v[31:0]);
    end
  endtask

  function automatic logic [31:0] rand_small();
    return 32'(signed'($urandom_range(0, 2 ** 22)) - (2 ** 21));
  endfunction

  initial begin
    logic [31:0] cfg [8];
    fail_count = 0;
    steady = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    seg_reg = '{32'd0, 32'd65536, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset segment, field extremes and both boundaries
    x_pending = '{32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'd65536, 32'd65537,
                  32'hffff_ffff, 32'd32768, 32'd1, 32'd65535, 32'h5555_5555,
                  32'haaaa_aaaa};
    drain();

    // Directed: curved unit segment, then saturating terms
    cfg = '{32'd0, 32'd65536, 32'hffff_0000, 32'd196608, 32'd131072,
            32'hfffe_0000, 32'd262144, 32'hfffc_0000};
    load_segment(cfg);
    x_pending = '{32'd0, 32'd16384, 32'd32768, 32'd49152, 32'd65536, 32'hffff_ffff};
    drain();
    cfg = '{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
            32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff};
    load_segment(cfg);
    x_pending = '{32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'h4000_0000, 32'hc000_0000};
    drain();

    // Zero-length and reversed segments
    cfg = '{32'd1000, 32'd1000, 32'd77, 32'd99, 32'd5, 32'd6, 32'd7, 32'd8};
    load_segment(cfg);
    x_pending = '{32'd999, 32'd1000, 32'd1001};
    drain();
    cfg[1] = 32'd500;
    load_segment(cfg);
    x_pending = '{32'd499, 32'd750, 32'd1001};
    drain();

    // Random phases: shortest segment, small curves, full-range registers
    for (int ph = 0; ph < 8; ph++) begin
      for (int i = 0; i < 8; i++) cfg[i] = (ph % 3 == 2) ? $urandom : rand_small();
      if (ph == 0) cfg[1] = cfg[0] + 32'd1;
      else if (ph % 3 != 2) cfg[1] = cfg[0] + 32'($urandom_range(1, 2 ** 20));
      if (ph == 7) steady = 1'b1;
      load_segment(cfg);
      queue_random(48);
      drain();
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
